// File: hdl/slmf_pkg.sv
// ----------------------------------------------------------------------------
// slmf_pkg
// Shared types, sizes and helpers for the scan line lane midpoint finder.
// ----------------------------------------------------------------------------
package slmf_pkg;

   // line and segment limits
   localparam int LINE_MAX     = 1024;
   localparam int MAX_SEGMENTS = 128;
   localparam int WIN_DEPTH    = 5;

   // derived widths
   localparam int IDX_W = $clog2(LINE_MAX);        // pixel position
   localparam int CNT_W = $clog2(LINE_MAX + 1);    // saturating pixel counter
   localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
   localparam int PIX_W = 8;
   localparam int MID_W = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_BLACK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_GREY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_WHITE = 2'd2;

   // pixel classes
   typedef logic [1:0] cls_type;
   localparam cls_type CLS_NONE  = 2'd0;
   localparam cls_type CLS_BLACK = 2'd1;
   localparam cls_type CLS_GREY  = 2'd2;
   localparam cls_type CLS_WHITE = 2'd3;

   // lane signature, oldest run first
   localparam cls_type LANE_PATTERN [WIN_DEPTH] =
      '{CLS_BLACK, CLS_WHITE, CLS_GREY, CLS_WHITE, CLS_BLACK};

   // one closed run
   typedef struct packed {
      cls_type          cls;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] last;
   } run_type;

   // runs closed by one pixel beat
   typedef struct packed {
      logic    eol;      // beat carries last pixel of the line
      logic    push_a;   // run closed by a class change
      run_type run_a;
      logic    push_b;   // run closed by end of line
      run_type run_b;
   } run_evt_type;

   // floor mean of run bounds
   function automatic logic [IDX_W-1:0] run_mid(input run_type r);
      logic [IDX_W:0] sum;
      sum = {1'b0, r.first} + {1'b0, r.last};
      return sum[IDX_W:1];
   endfunction

endpackage

// File: hdl/scanline_lane_midpoint_finder.sv
// ----------------------------------------------------------------------------
// scanline_lane_midpoint_finder
// Finds the center of the grey lane between white markings on a scan line.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ stream, one beat per pixel, req_tlast on the final
// pixel of the line. One pixel per clock is sustained while req_tready is high.
// Closed runs move through a row of five window cells, one step per closed run.
// One result beat leaves on the rsp_ stream per line, registered once the
// last pixel is taken: rsp_tuser is found, rsp_tdata the grey run midpoint
// (zero when not found).
// The result sits in an output register backed by one skid entry, so pixels
// keep flowing while a result waits. req_tready drops only when both hold a
// result, that is when the receiver stalls across two line ends.
// The csr_ port writes the black, grey and white levels (index 0, 1, 2); it
// is always ready and writes to index 3 are ignored.
// Synchronous reset clears line state and the result valid flags, and sets
// levels to 0, 128 and 255. No clearing pass is needed.
// ----------------------------------------------------------------------------
module scanline_lane_midpoint_finder (
   input  logic                            clock,
   input  logic                            reset,
   // pixel stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] pixel
   input  logic                            req_tlast,   // last_pixel
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // [9:0] midpoint, rest zero
   output logic                            rsp_tuser,   // found
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [slmf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slmf_pkg::CSR_DAT_W-1:0]  csr_data
);
   import slmf_pkg::*;

   logic [PIX_W-1:0] level_black_ff, level_grey_ff, level_white_ff;

   run_evt_type evt;
   run_type     win [WIN_DEPTH];
   logic        win_shift;

   logic [SEG_W-1:0] seg_ff, seg_in, seg_a;
   logic             seen_ff, seen_in, seen_a, seen_b;
   logic [IDX_W-1:0] mid_ff, mid_in, mid_a, mid_b;
   logic             ok_a, ok_b, hit_a, hit_b;
   cls_type          cls_b [WIN_DEPTH];
   run_type          grey_b;

   logic             out_v_ff, skid_v_ff, out_v_in, skid_v_in;
   logic             out_found_ff, skid_found_ff, out_found_in, skid_found_in;
   logic [MID_W-1:0] out_mid_ff, skid_mid_ff, out_mid_in, skid_mid_in;
   logic             res_v;
   logic             res_found;
   logic [MID_W-1:0] res_mid;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_black_ff <= 8'd0;
         level_grey_ff  <= 8'd128;
         level_white_ff <= 8'd255;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LEVEL_BLACK: level_black_ff <= csr_data;
            REG_LEVEL_GREY:  level_grey_ff  <= csr_data;
            REG_LEVEL_WHITE: level_white_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pixel classification and run tracking
   assign req_tready = !skid_v_ff;

   slmf_run_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_tvalid && req_tready),
      .pixel       (req_tdata[PIX_W-1:0]),
      .last_pixel  (req_tlast),
      .level_black (level_black_ff),
      .level_grey  (level_grey_ff),
      .level_white (level_white_ff),
      .evt         (evt)
   );

   // window row, newest run in the top cell
   assign win_shift = ok_a && !evt.eol;

   for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_win
      if (k == WIN_DEPTH - 1) begin : g_top
         slmf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (win_shift),
            .clear   (evt.eol),
            .run_in  (evt.run_a),
            .run_out (win[k])
         );
      end else begin : g_mid
         slmf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (win_shift),
            .clear   (evt.eol),
            .run_in  (win[k+1]),
            .run_out (win[k])
         );
      end
   end

   // pattern check; the end-of-line run may follow a class change run
   always_comb begin
      ok_a  = evt.push_a && (seg_ff < SEG_W'(MAX_SEGMENTS));
      hit_a = ok_a && !seen_ff && (evt.run_a.cls == LANE_PATTERN[WIN_DEPTH-1]);
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
         if (win[k+1].cls != LANE_PATTERN[k]) begin
            hit_a = 1'b0;
         end
      end
      seg_a  = ok_a ? seg_ff + SEG_W'(1) : seg_ff;
      seen_a = seen_ff || hit_a;
      mid_a  = hit_a ? run_mid(win[3]) : mid_ff;

      // window as seen by the end-of-line run
      for (int k = 0; k < WIN_DEPTH - 2; k++) begin
         cls_b[k] = ok_a ? win[k+2].cls : win[k+1].cls;
      end
      cls_b[WIN_DEPTH-2] = ok_a ? evt.run_a.cls : win[WIN_DEPTH-1].cls;
      cls_b[WIN_DEPTH-1] = evt.run_b.cls;
      grey_b = ok_a ? win[4] : win[3];

      ok_b  = evt.push_b && (seg_a < SEG_W'(MAX_SEGMENTS));
      hit_b = ok_b && !seen_a;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         if (cls_b[k] != LANE_PATTERN[k]) begin
            hit_b = 1'b0;
         end
      end
      seen_b = seen_a || hit_b;
      mid_b  = hit_b ? run_mid(grey_b) : mid_a;

      // line state
      if (evt.eol) begin
         seg_in  = '0;
         seen_in = 1'b0;
         mid_in  = '0;
      end else begin
         seg_in  = seg_a;
         seen_in = seen_a;
         mid_in  = mid_a;
      end

      res_v     = evt.eol;
      res_found = seen_b;
      res_mid   = seen_b ? MID_W'(mid_b) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff  <= '0;
         seen_ff <= 1'b0;
         mid_ff  <= '0;
      end else begin
         seg_ff  <= seg_in;
         seen_ff <= seen_in;
         mid_ff  <= mid_in;
      end
   end

   // output register with one skid entry
   always_comb begin
      out_v_in      = out_v_ff;
      out_found_in  = out_found_ff;
      out_mid_in    = out_mid_ff;
      skid_v_in     = skid_v_ff;
      skid_found_in = skid_found_ff;
      skid_mid_in   = skid_mid_ff;
      if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_in     = 1'b1;
            out_found_in = skid_found_ff;
            out_mid_in   = skid_mid_ff;
            skid_v_in    = 1'b0;
         end else begin
            out_v_in     = res_v;
            out_found_in = res_found;
            out_mid_in   = res_mid;
         end
      end else if (res_v) begin
         skid_v_in     = 1'b1;
         skid_found_in = res_found;
         skid_mid_in   = res_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_found_ff  <= out_found_in;
      out_mid_ff    <= out_mid_in;
      skid_found_ff <= skid_found_in;
      skid_mid_ff   <= skid_mid_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = {{(16 - MID_W){1'b0}}, out_mid_ff};

endmodule

// File: hdl/slmf_cell.sv
// ----------------------------------------------------------------------------
// slmf_cell
// One window slot: holds a closed run and hands it to the older neighbor.
// ----------------------------------------------------------------------------
module slmf_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic             clear,
   input  slmf_pkg::run_type run_in,
   output slmf_pkg::run_type run_out
);
   import slmf_pkg::*;

   run_type entry_ff;

   // class is control state; bounds only matter behind a nonzero class
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         entry_ff.cls <= CLS_NONE;
      end else if (shift) begin
         entry_ff.cls <= run_in.cls;
      end
      if (shift) begin
         entry_ff.first <= run_in.first;
         entry_ff.last  <= run_in.last;
      end
   end

   assign run_out = entry_ff;

endmodule

// File: hdl/slmf_run_tracker.sv
// ----------------------------------------------------------------------------
// slmf_run_tracker
// Classifies pixels, tracks the open run and reports runs as they close.
// ----------------------------------------------------------------------------
module slmf_run_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [slmf_pkg::PIX_W-1:0]  pixel,
   input  logic                        last_pixel,
   input  logic [slmf_pkg::PIX_W-1:0]  level_black,
   input  logic [slmf_pkg::PIX_W-1:0]  level_grey,
   input  logic [slmf_pkg::PIX_W-1:0]  level_white,
   output slmf_pkg::run_evt_type       evt
);
   import slmf_pkg::*;

   logic [CNT_W-1:0] idx_ff, idx_in;
   cls_type          run_cls_ff, run_cls_in;
   logic [IDX_W-1:0] run_start_ff, run_start_in;

   logic             in_range;
   logic [IDX_W-1:0] pos;
   cls_type          cls;
   logic             change;
   cls_type          open_cls;
   logic [IDX_W-1:0] open_start;

   // classify, black first
   always_comb begin
      in_range = (idx_ff < CNT_W'(LINE_MAX));
      pos      = idx_ff[IDX_W-1:0];
      cls      = CLS_NONE;
      if (in_range) begin
         if (pixel == level_black) begin
            cls = CLS_BLACK;
         end else if (pixel == level_grey) begin
            cls = CLS_GREY;
         end else if (pixel == level_white) begin
            cls = CLS_WHITE;
         end
      end
      change     = (cls != CLS_NONE) && (cls != run_cls_ff);
      open_cls   = change ? cls : run_cls_ff;
      open_start = change ? pos : run_start_ff;
   end

   // closed runs of this beat
   always_comb begin
      evt.eol         = accept && last_pixel;
      evt.push_a      = accept && change && (run_cls_ff != CLS_NONE);
      evt.run_a.cls   = run_cls_ff;
      evt.run_a.first = run_start_ff;
      evt.run_a.last  = pos - IDX_W'(1);
      evt.push_b      = accept && last_pixel && (open_cls != CLS_NONE);
      evt.run_b.cls   = open_cls;
      evt.run_b.first = open_start;
      evt.run_b.last  = in_range ? pos : IDX_W'(LINE_MAX - 1);
   end

   // line state update, counter saturates at the line limit
   always_comb begin
      idx_in       = idx_ff;
      run_cls_in   = run_cls_ff;
      run_start_in = run_start_ff;
      if (accept) begin
         if (last_pixel) begin
            idx_in       = '0;
            run_cls_in   = CLS_NONE;
            run_start_in = '0;
         end else begin
            run_cls_in   = open_cls;
            run_start_in = open_start;
            if (in_range) begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         run_cls_ff   <= CLS_NONE;
         run_start_ff <= '0;
      end else begin
         idx_ff       <= idx_in;
         run_cls_ff   <= run_cls_in;
         run_start_ff <= run_start_in;
      end
   end

endmodule

// File: tb/scanline_lane_midpoint_finder_tb.sv
// ----------------------------------------------------------------------------
// scanline_lane_midpoint_finder_tb
// Self-checking bench for the scan line lane midpoint finder.
// ----------------------------------------------------------------------------
// Pixel lines are streamed into req_, one beat per pixel, and the line
// results on rsp_ are checked against an in-bench tracker of runs and the
// five-run window. Named tests cover reset levels, level register writes
// (equal and extreme levels), a line past the length limit, the run limit,
// and random lines shaped mostly around the lane signature. Both streams
// idle and stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module scanline_lane_midpoint_finder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import slmf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;   // no register behind it
   localparam int IDLE_PCT = 27;
   localparam int RANDOM_PIXELS = 600;

   // lane signature, oldest run first
   localparam cls_type LANE_SIG [WIN_DEPTH] =
      '{CLS_BLACK, CLS_WHITE, CLS_GREY, CLS_WHITE, CLS_BLACK};

   typedef struct packed {
      logic             found;
      logic [MID_W-1:0] midpoint;
   } line_verdict_type;

   // dut ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;    // [7:0] pixel
   logic                 req_tlast = 1'b0;  // last_pixel
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;         // [9:0] midpoint, rest zero
   logic                 rsp_tuser;         // found
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   // tracker state: levels and one line of runs
   logic [7:0]       px_black, px_grey, px_white;
   logic [CNT_W-1:0] pix_pos;
   cls_type          run_cls;
   logic [IDX_W-1:0] run_first;
   cls_type          win_cls   [WIN_DEPTH];
   logic [IDX_W-1:0] win_first [WIN_DEPTH];
   logic [IDX_W-1:0] win_last  [WIN_DEPTH];
   int               seg_count;
   logic             lane_seen;
   logic [IDX_W-1:0] lane_mid;

   line_verdict_type line_verdicts [$];
   logic [7:0]       line_buf [$];

   int error_count = 0;
   int pixels_sent = 0;
   int noise_pct = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;

   scanline_lane_midpoint_finder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // tracker
   // ------------------------------------------------------------------------
   function automatic void clear_line_state();
      pix_pos   = '0;
      run_cls   = CLS_NONE;
      run_first = '0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         win_cls[k]   = CLS_NONE;
         win_first[k] = '0;
         win_last[k]  = '0;
      end
      seg_count = 0;
      lane_seen = 1'b0;
      lane_mid  = '0;
   endfunction

   // shift one closed run into the window and look for the signature
   function automatic void close_run(cls_type cls, logic [IDX_W-1:0] first,
                                     logic [IDX_W-1:0] last);
      logic           hit;
      logic [IDX_W:0] sum;
      if (seg_count >= MAX_SEGMENTS) return;
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
         win_cls[k]   = win_cls[k+1];
         win_first[k] = win_first[k+1];
         win_last[k]  = win_last[k+1];
      end
      win_cls[WIN_DEPTH-1]   = cls;
      win_first[WIN_DEPTH-1] = first;
      win_last[WIN_DEPTH-1]  = last;
      seg_count++;
      if (lane_seen || seg_count < WIN_DEPTH) return;
      hit = 1'b1;
      for (int k = 0; k < WIN_DEPTH; k++)
         if (win_cls[k] != LANE_SIG[k]) hit = 1'b0;
      if (hit) begin
         sum       = {1'b0, win_first[2]} + {1'b0, win_last[2]};
         lane_seen = 1'b1;
         lane_mid  = sum[IDX_W:1];
      end
   endfunction

   // one accepted pixel beat; queues the line verdict on the last pixel
   function automatic void track_lane_pixel(logic [7:0] px, logic last);
      cls_type          cls;
      logic [IDX_W-1:0] end_pos;
      line_verdict_type v;
      cls = CLS_NONE;
      if (pix_pos < LINE_MAX) begin
         if (px == px_black)      cls = CLS_BLACK;
         else if (px == px_grey)  cls = CLS_GREY;
         else if (px == px_white) cls = CLS_WHITE;
      end
      if (cls != CLS_NONE && cls != run_cls) begin
         if (run_cls != CLS_NONE)
            close_run(run_cls, run_first, IDX_W'(pix_pos - 1'b1));
         run_cls   = cls;
         run_first = pix_pos[IDX_W-1:0];
      end
      if (last) begin
         end_pos = (pix_pos < LINE_MAX) ? pix_pos[IDX_W-1:0] : IDX_W'(LINE_MAX - 1);
         if (run_cls != CLS_NONE) close_run(run_cls, run_first, end_pos);
         v.found    = lane_seen;
         v.midpoint = lane_seen ? MID_W'(lane_mid) : '0;
         line_verdicts.push_back(v);
         clear_line_state();
      end else if (pix_pos < LINE_MAX) begin
         pix_pos = pix_pos + 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // monitor: level writes, pixel beats and result checks
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      line_verdict_type want;
      if (reset) begin
         px_black = 8'd0;
         px_grey  = 8'd128;
         px_white = 8'd255;
         clear_line_state();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LEVEL_BLACK: px_black = csr_data;
               REG_LEVEL_GREY:  px_grey  = csr_data;
               REG_LEVEL_WHITE: px_white = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) track_lane_pixel(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (line_verdicts.size() == 0) begin
               $error("result beat with no line pending: found %0d midpoint %0d",
                      rsp_tuser, rsp_tdata[MID_W-1:0]);
               error_count++;
            end else begin
               want = line_verdicts.pop_front();
               if (rsp_tuser !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[MID_W-1:0] !== want.midpoint) begin
                  $error("midpoint: expected %0d, got %0d", want.midpoint,
                         rsp_tdata[MID_W-1:0]);
                  error_count++;
               end
               if (rsp_tdata[15:MID_W] !== '0) begin
                  $error("tdata pad: expected 0, got %0h", rsp_tdata[15:MID_W]);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock)
      rsp_tready = !(rsp_stalls_on && $urandom_range(99) < IDLE_PCT);

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_pixel(input logic [7:0] px, input logic last);
      @(negedge clock);
      while (req_gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = px;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic send_line();
      for (int n = 0; n < line_buf.size(); n++)
         send_pixel(line_buf[n], n == line_buf.size() - 1);
      line_buf.delete();
   endtask

   // stop sending and wait until every line result is back
   task automatic settle_block();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (line_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_level(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      settle_block();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_levels(input logic [7:0] b, input logic [7:0] g, input logic [7:0] w);
      write_level(REG_LEVEL_BLACK, b);
      write_level(REG_LEVEL_GREY, g);
      write_level(REG_LEVEL_WHITE, w);
   endtask

   // ------------------------------------------------------------------------
   // line builders
   // ------------------------------------------------------------------------
   function automatic logic [7:0] noise_pixel();
      logic [7:0] v;
      do v = 8'($urandom_range(255));
      while (v == px_black || v == px_grey || v == px_white);
      return v;
   endfunction

   function automatic logic [7:0] level_of(cls_type cls);
      case (cls)
         CLS_BLACK: return px_black;
         CLS_GREY:  return px_grey;
         default:   return px_white;
      endcase
   endfunction

   // len pixels of one class, noise sprinkled in at noise_pct
   function automatic void add_run(cls_type cls, int len);
      for (int n = 0; n < len; n++) begin
         if ($urandom_range(99) < noise_pct) line_buf.push_back(noise_pixel());
         line_buf.push_back(level_of(cls));
      end
   endfunction

   function automatic void add_lane(int max_len);
      for (int k = 0; k < WIN_DEPTH; k++) add_run(LANE_SIG[k], $urandom_range(1, max_len));
   endfunction

   function automatic void add_random_runs(int count, int max_len);
      for (int k = 0; k < count; k++)
         add_run(cls_type'($urandom_range(1, 3)), $urandom_range(1, max_len));
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset levels: minimal lane, lane with noise, empty and single-run lines
   task automatic test_directed_lines();
      line_buf = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0};
      send_line();
      line_buf = '{8'd0, 8'd0, 8'd7, 8'd255, 8'd255, 8'd128, 8'd9, 8'd128,
                   8'd128, 8'd255, 8'd0, 8'd0};
      send_line();
      line_buf = '{8'd200};
      send_line();
      line_buf = '{8'd128, 8'd128};
      send_line();
   endtask

   // every register, unused index, extreme and equal levels
   task automatic test_level_registers();
      noise_pct = 10;
      set_levels(8'd255, 8'd0, 8'd77);
      write_level(REG_UNUSED, 8'd128);
      add_lane(3);
      send_line();
      // all equal: everything reads as black
      set_levels(8'd50, 8'd50, 8'd50);
      add_lane(2);
      send_line();
      // grey and white equal: white pixels read as grey
      set_levels(8'd10, 8'd60, 8'd60);
      add_lane(2);
      send_line();
      set_levels(8'd0, 8'd128, 8'd255);
      add_run(CLS_BLACK, 2);
      add_lane(2);
      line_buf.push_back(noise_pixel());
      send_line();
   endtask

   // lane right at the length limit, last pixel well beyond it
   task automatic test_long_line();
      noise_pct = 0;
      for (int n = 0; n < LINE_MAX - 14; n++) line_buf.push_back(noise_pixel());
      add_run(CLS_BLACK, 2);
      add_run(CLS_WHITE, 2);
      add_run(CLS_GREY, 6);
      add_run(CLS_WHITE, 2);
      add_run(CLS_BLACK, 2);
      // classed values past the limit are ignored
      add_run(CLS_WHITE, 4);
      add_run(CLS_GREY, 4);
      send_line();
   endtask

   // lane as the last runs allowed, one run too late, and far beyond
   task automatic test_segment_limit();
      noise_pct = 0;
      for (int k = 0; k < MAX_SEGMENTS - WIN_DEPTH; k++)
         add_run((k % 2 == 0) ? CLS_GREY : CLS_BLACK, 1);
      add_lane(1);
      add_random_runs(4, 2);
      send_line();
      for (int k = 0; k < MAX_SEGMENTS - WIN_DEPTH + 1; k++)
         add_run((k % 2 == 0) ? CLS_BLACK : CLS_GREY, 1);
      add_lane(1);
      send_line();
      for (int k = 0; k < MAX_SEGMENTS + 4; k++)
         add_run((k % 2 == 0) ? CLS_BLACK : CLS_GREY, 1);
      add_lane(2);
      send_line();
   endtask

   // mostly lane-shaped lines with random content, some broken or noise only
   task automatic random_lines(input int pixel_budget);
      int stop_at;
      int pick;
      stop_at = pixels_sent + pixel_budget;
      while (pixels_sent < stop_at) begin
         pick = $urandom_range(99);
         noise_pct = $urandom_range(0, 20);
         if (pick < 70) begin
            add_random_runs($urandom_range(0, 2), 4);
            add_lane(6);
            add_random_runs($urandom_range(0, 2), 4);
         end else if (pick < 90) begin
            add_random_runs($urandom_range(1, 8), 5);
         end else begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(255)));
         end
         if ($urandom_range(3) == 0) line_buf.push_back(noise_pixel());
         if ($urandom_range(14) == 0) settle_block();
         send_line();
      end
   endtask

   task automatic test_random_lines();
      logic [7:0] b, g;
      // random levels, black and grey distinct, full rate on both sides
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      b = 8'($urandom_range(255));
      do g = 8'($urandom_range(255)); while (g == b);
      set_levels(b, g, ~b ^ g);
      random_lines(RANDOM_PIXELS / 4);
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      // random levels, possibly equal
      set_levels(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      random_lines(RANDOM_PIXELS / 4);
      // extremes
      set_levels(8'd255, 8'd0, 8'd170);
      random_lines(RANDOM_PIXELS / 4);
      set_levels(8'd0, 8'd128, 8'd255);
      random_lines(RANDOM_PIXELS / 4);
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_lines();
      test_level_registers();
      test_long_line();
      test_segment_limit();
      test_random_lines();
      settle_block();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
